// ===== rtl/keyboard_scancode_queue_adapter_assert.svh =====
// Assertion macros used by the adapter's datapath.
// Each macro checks one implication on the rising clock edge, with reset masked.
`ifndef KEYBOARD_SCANCODE_QUEUE_ADAPTER_ASSERT_SVH
`define KEYBOARD_SCANCODE_QUEUE_ADAPTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KBSQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kbsq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KBSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kbsq assertion failed");

`endif

// ===== rtl/kbsq_pkg.sv =====
package kbsq_pkg;

    // Default queue size and the longest read burst after the count byte.
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_READ        = 63;

    // Request opcodes.
    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_ENV  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Scan code bytes with a special meaning.
    localparam logic [7:0] CODE_NONE = 8'h00;
    localparam logic [7:0] PFX_EXT   = 8'hE0;
    localparam logic [7:0] CODE_E1   = 8'hE1;
    localparam logic [7:0] PFX_BRK   = 8'hF0;
    localparam logic [7:0] CODE_F8   = 8'hF8;

    // Host envelope bytes.
    localparam logic [7:0] TAG_K      = 8'h4B;
    localparam logic [7:0] CMD_RESET  = 8'hFF;
    localparam logic [7:0] CMD_LEDS   = 8'hED;
    localparam logic [7:0] CMD_RATE   = 8'hF3;
    localparam logic [7:0] RATE_TRAIL = 8'hF4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] key_code;
        logic       key_extended;
        logic       key_down;
        logic [7:0] env_size;
        logic [7:0] env_tag;
        logic [7:0] env_len;
        logic [7:0] env_cmd;
        logic [7:0] env_arg;
        logic [7:0] env_arg2;
        logic [6:0] read_capacity;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [7:0]  data_byte;
        logic        last;
        logic [2:0]  leds_now;
        logic [6:0]  repeat_now;
        logic [31:0] dropped_total;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH,
        S_RESULT,
        S_RD_CNT,
        S_RD_DATA
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic push;
        logic load_res;
        logic load_cnt;
        logic load_data;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic push_go;
        logic read_go;
        logic push_last;
        logic out_free;
        logic n_zero;
        logic n_one;
    } t_stat;

endpackage

// ===== rtl/keyboard_scancode_queue_adapter.sv =====
// Keyboard scan code queue adapter.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one request at a time:
// a key event, a host command envelope or a read. Output channel (o_out_valid /
// i_out_ready / o_out_data) returns results through a single output register.
// A key event, envelope, zero-capacity read or unused opcode gives one result; any other
// read gives a count byte and then that many queued bytes, the final result flagged by last.
// Sequence: a request is latched on acceptance and decoded in the EXEC state; a queued
// key event then writes its one to three bytes into the queue memory, one per cycle.
// Envelopes, reads and rejected or dropped key events go from decode straight to
// loading their first result, and a queued key event loads it after its last byte is
// written. Read bytes follow at one per cycle while the output register is free,
// paced by the registered read port of the queue memory, which is fetched one byte
// ahead. The next request is taken once the last result of the previous one sits in
// the output register.
// Reset clears the queue pointers, LED mask, repeat rate, drop counter and the
// output valid flag; the queue memory itself is not cleared.
// When the receiver holds i_out_ready low, the pending result stays in place and
// the block waits before loading the next one.
module keyboard_scancode_queue_adapter #(
    parameter int QUEUE_DEPTH = kbsq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kbsq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kbsq_pkg::t_out_item o_out_data
);

    kbsq_pkg::t_cmd  w_cmd;
    kbsq_pkg::t_stat w_stat;

    // Sequencer.
    kbsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Queue, settings and output register.
    kbsq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/kbsq_ctrl.sv =====
module kbsq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  kbsq_pkg::t_stat i_stat,
    output kbsq_pkg::t_cmd  o_cmd
);

    kbsq_pkg::t_state r_state;
    kbsq_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kbsq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            kbsq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = kbsq_pkg::S_EXEC;
                end
            end
            kbsq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.push_go) begin
                    n_state = kbsq_pkg::S_PUSH;
                end else if (i_stat.read_go) begin
                    n_state = kbsq_pkg::S_RD_CNT;
                end else begin
                    n_state = kbsq_pkg::S_RESULT;
                end
            end
            kbsq_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_stat.push_last) begin
                    n_state = kbsq_pkg::S_RESULT;
                end
            end
            kbsq_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = kbsq_pkg::S_IDLE;
                end
            end
            kbsq_pkg::S_RD_CNT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_cnt = 1'b1;
                    n_state = i_stat.n_zero ? kbsq_pkg::S_IDLE : kbsq_pkg::S_RD_DATA;
                end
            end
            kbsq_pkg::S_RD_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.load_data = 1'b1;
                    if (i_stat.n_one) begin
                        n_state = kbsq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = kbsq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/kbsq_datapath.sv =====
module kbsq_datapath #(
    parameter int QUEUE_DEPTH = kbsq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kbsq_pkg::t_in_item  i_in_data,
    input  kbsq_pkg::t_cmd      i_cmd,
    output kbsq_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kbsq_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(QUEUE_DEPTH);

    // Queue storage and pointers.
    logic [7:0]          r_mem [QUEUE_DEPTH];
    logic [7:0]          r_rd_data;
    logic [AW-1:0]       r_head;
    logic [AW-1:0]       r_tail;
    logic [CW-1:0]       r_count;

    // Adapter settings and the drop counter.
    logic [2:0]          r_leds;
    logic [6:0]          r_repeat;
    logic [31:0]         r_drops;

    // Request being worked on.
    kbsq_pkg::t_in_item  r_item;
    logic                r_ok;
    logic [2:0]          r_pend;
    logic [5:0]          r_n;

    // Output register.
    kbsq_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [AW-1:0]       w_head_inc;
    logic [AW-1:0]       w_tail_inc;
    logic                w_reserved;
    logic [1:0]          w_nbytes;
    logic                w_fits;
    logic [7:0]          w_push_byte;
    logic [6:0]          w_capm1;
    logic [5:0]          w_lim;
    logic [5:0]          w_n;
    logic                w_env_hdr;
    logic                w_do_reset;
    logic                w_do_leds;
    logic                w_do_rate;
    logic                w_out_free;
    logic                w_load;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic [SW-1:0]       w_tail_sum;
    logic [SW-1:0]       w_tail_wrap;
    logic [AW-1:0]       w_tail_calc;

    // Ring pointer increments.
    assign w_head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign w_tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;

    // Key event checks: reserved codes and room for the whole sequence.
    assign w_reserved = (r_item.key_code == kbsq_pkg::CODE_NONE)
                     || (r_item.key_code == kbsq_pkg::PFX_EXT)
                     || (r_item.key_code == kbsq_pkg::CODE_E1)
                     || (r_item.key_code == kbsq_pkg::PFX_BRK)
                     || (r_item.key_code == kbsq_pkg::CODE_F8);
    assign w_nbytes = 2'd1 + {1'b0, r_item.key_extended} + {1'b0, ~r_item.key_down};
    assign w_fits   = ({1'b0, r_count} + (CW + 1)'(w_nbytes)) <= DEPTH_X;

    // The pending mask holds prefix, break and code flags; the highest goes first.
    always_comb begin
        if (r_pend[2]) begin
            w_push_byte = kbsq_pkg::PFX_EXT;
        end else if (r_pend[1]) begin
            w_push_byte = kbsq_pkg::PFX_BRK;
        end else begin
            w_push_byte = r_item.key_code;
        end
    end

    // Read length: the smaller of the fill level, capacity less one and the burst limit.
    assign w_capm1 = r_item.read_capacity - 7'd1;
    assign w_lim   = (w_capm1 > 7'(kbsq_pkg::MAX_READ)) ? 6'(kbsq_pkg::MAX_READ)
                                                        : w_capm1[5:0];
    assign w_n     = (8'(r_count) < 8'(w_lim)) ? 6'(r_count) : w_lim;

    // Envelope decode.
    assign w_env_hdr  = (r_item.env_size >= 8'd2) && (r_item.env_tag == kbsq_pkg::TAG_K)
                     && (r_item.env_len <= (r_item.env_size - 8'd2));
    assign w_do_reset = w_env_hdr && (r_item.env_len == 8'd1)
                     && (r_item.env_cmd == kbsq_pkg::CMD_RESET);
    assign w_do_leds  = w_env_hdr && (r_item.env_len == 8'd2)
                     && (r_item.env_cmd == kbsq_pkg::CMD_LEDS)
                     && (r_item.env_arg[7:3] == 5'd0);
    assign w_do_rate  = w_env_hdr && (r_item.env_len == 8'd3)
                     && (r_item.env_cmd == kbsq_pkg::CMD_RATE)
                     && (r_item.env_size >= 8'd5)
                     && (r_item.env_arg2 == kbsq_pkg::RATE_TRAIL)
                     && !r_item.env_arg[7];

    // The output register may be loaded when empty or when its result leaves now.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load     = i_cmd.load_res || i_cmd.load_cnt || i_cmd.load_data;

    // Queue reads run one byte ahead of the output register.
    assign w_rd_en   = (i_cmd.load_cnt && (r_n != 6'd0)) || (i_cmd.load_data && (r_n != 6'd1));
    assign w_rd_addr = i_cmd.load_cnt ? r_head : w_head_inc;

    // Status to the controller.
    always_comb begin
        o_stat.push_go   = (r_item.opcode == kbsq_pkg::OP_KEY) && !w_reserved && w_fits;
        o_stat.read_go   = (r_item.opcode == kbsq_pkg::OP_READ)
                        && (r_item.read_capacity != 7'd0);
        o_stat.push_last = (r_pend[2:1] == 2'b00);
        o_stat.out_free  = w_out_free;
        o_stat.n_zero    = (r_n == 6'd0);
        o_stat.n_one     = (r_n == 6'd1);
    end

    // Queue memory write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= w_push_byte;
        end
    end

    // Queue memory read port.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Request payload and per-request working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_n <= w_n;
            case (r_item.opcode)
                kbsq_pkg::OP_KEY:  r_ok <= !w_reserved && w_fits;
                kbsq_pkg::OP_ENV:  r_ok <= w_do_reset || w_do_leds || w_do_rate;
                default:           r_ok <= 1'b0;
            endcase
        end else if (i_cmd.load_data) begin
            r_n <= r_n - 6'd1;
        end
    end

    // Queue pointers, settings and the drop counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_leds   <= '0;
            r_repeat <= '0;
            r_drops  <= '0;
            r_pend   <= '0;
        end else begin
            if (i_cmd.exec) begin
                case (r_item.opcode)
                    kbsq_pkg::OP_KEY: begin
                        if (!w_reserved) begin
                            if (w_fits) begin
                                r_pend <= {r_item.key_extended, ~r_item.key_down, 1'b1};
                            end else begin
                                r_drops <= r_drops + 32'd1;
                            end
                        end
                    end
                    kbsq_pkg::OP_ENV: begin
                        if (w_do_reset) begin
                            r_head   <= '0;
                            r_tail   <= '0;
                            r_count  <= '0;
                            r_leds   <= '0;
                            r_repeat <= '0;
                        end
                        if (w_do_leds) begin
                            r_leds <= r_item.env_arg[2:0];
                        end
                        if (w_do_rate) begin
                            r_repeat <= r_item.env_arg[6:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.push) begin
                r_tail  <= w_tail_inc;
                r_count <= r_count + 1'b1;
                if (r_pend[2]) begin
                    r_pend[2] <= 1'b0;
                end else if (r_pend[1]) begin
                    r_pend[1] <= 1'b0;
                end else begin
                    r_pend[0] <= 1'b0;
                end
            end
            if (i_cmd.load_data) begin
                r_head  <= w_head_inc;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.leds_now      <= r_leds;
            r_out.repeat_now    <= r_repeat;
            r_out.dropped_total <= r_drops;
            if (i_cmd.load_cnt) begin
                r_out.ok        <= 1'b1;
                r_out.data_byte <= 8'(r_n);
                r_out.last      <= (r_n == 6'd0);
            end else if (i_cmd.load_data) begin
                r_out.ok        <= 1'b1;
                r_out.data_byte <= r_rd_data;
                r_out.last      <= (r_n == 6'd1);
            end else begin
                r_out.ok        <= r_ok;
                r_out.data_byte <= 8'd0;
                r_out.last      <= 1'b1;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Expected write position, derived from head and fill level.
    assign w_tail_sum  = {1'b0, r_head} + SW'(r_count);
    assign w_tail_wrap = (w_tail_sum >= DEPTH_S) ? w_tail_sum - DEPTH_S : w_tail_sum;
    assign w_tail_calc = AW'(w_tail_wrap);

    `include "keyboard_scancode_queue_adapter_assert.svh"

    `KBSQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C)
    `KBSQ_ASSERT_SAME(a_tail_track, i_clk, i_rst_n, 1'b1, r_tail == w_tail_calc)
    `KBSQ_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !w_load)
    `KBSQ_ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, i_cmd.load_data, r_count != '0)

endmodule

// ===== verif/keyboard_scancode_queue_adapter_tb.sv =====
module keyboard_scancode_queue_adapter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH       = kbsq_pkg::QUEUE_DEPTH_DEF;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         REPORT_MAX  = 10;
    localparam int         TAIL_CYCLES = 20;
    localparam logic [1:0] OP_SPARE    = 2'd3;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    kbsq_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    kbsq_pkg::t_out_item o_out_data;

    // Mirror of the adapter's state, advanced once per accepted request.
    logic [7:0]  mirror_fifo [DEPTH];
    int unsigned mirror_head  = 0;
    int unsigned mirror_count = 0;
    logic [2:0]  mirror_leds  = '0;
    logic [6:0]  mirror_rate  = '0;
    logic [31:0] mirror_drops = '0;

    // Results still owed by the adapter, oldest first.
    kbsq_pkg::t_out_item pending_results [$];

    bit          calm          = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned fault_count   = 0;
    int unsigned drop_events   = 0;
    int unsigned full_reads    = 0;

    keyboard_scancode_queue_adapter #(
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running clock, 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The receiver stalls at random, with a chance of 30 in 100, except in calm stretches.
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 30);
    end

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic logic reserved_code(logic [7:0] code);
        return (code == kbsq_pkg::CODE_NONE) || (code == kbsq_pkg::PFX_EXT) ||
               (code == kbsq_pkg::CODE_E1) || (code == kbsq_pkg::PFX_BRK) ||
               (code == kbsq_pkg::CODE_F8);
    endfunction

    // One result carrying the status registers as they stand now.
    function automatic kbsq_pkg::t_out_item status_result(logic ok, logic [7:0] data,
                                                          logic last);
        kbsq_pkg::t_out_item res;
        res.ok            = ok;
        res.data_byte     = data;
        res.last          = last;
        res.leds_now      = mirror_leds;
        res.repeat_now    = mirror_rate;
        res.dropped_total = mirror_drops;
        return res;
    endfunction

    // A key event queues its prefixes and code all together, or is dropped whole.
    function automatic logic apply_key_event(kbsq_pkg::t_in_item req);
        logic [7:0]  seq [3];
        int unsigned n;
        n = 0;
        if (reserved_code(req.key_code)) begin
            return 1'b0;
        end
        if (req.key_extended) begin
            seq[n] = kbsq_pkg::PFX_EXT;
            n++;
        end
        if (!req.key_down) begin
            seq[n] = kbsq_pkg::PFX_BRK;
            n++;
        end
        seq[n] = req.key_code;
        n++;
        if (n > DEPTH - mirror_count) begin
            mirror_drops = mirror_drops + 32'd1;
            drop_events++;
            return 1'b0;
        end
        for (int j = 0; j < n; j++) begin
            mirror_fifo[(mirror_head + mirror_count) % DEPTH] = seq[j];
            mirror_count++;
        end
        return 1'b1;
    endfunction

    // Host envelope: framing checks first, then one of the three commands.
    function automatic logic apply_envelope(kbsq_pkg::t_in_item req);
        if (req.env_size < 8'd2 || req.env_tag != kbsq_pkg::TAG_K ||
            req.env_len > req.env_size - 8'd2) begin
            return 1'b0;
        end
        if (req.env_len == 8'd1 && req.env_cmd == kbsq_pkg::CMD_RESET) begin
            mirror_head  = 0;
            mirror_count = 0;
            mirror_leds  = '0;
            mirror_rate  = '0;
            return 1'b1;
        end
        if (req.env_len == 8'd2 && req.env_cmd == kbsq_pkg::CMD_LEDS &&
            req.env_arg[7:3] == 5'd0) begin
            mirror_leds = req.env_arg[2:0];
            return 1'b1;
        end
        if (req.env_len == 8'd3 && req.env_cmd == kbsq_pkg::CMD_RATE && req.env_size >= 8'd5 &&
            req.env_arg2 == kbsq_pkg::RATE_TRAIL && !req.env_arg[7]) begin
            mirror_rate = req.env_arg[6:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Works out every result of one accepted request and queues them in order.
    function automatic void predict_results(kbsq_pkg::t_in_item req);
        logic        ok;
        int unsigned n;
        case (req.opcode)
            kbsq_pkg::OP_KEY: begin
                ok = apply_key_event(req);
                pending_results.push_back(status_result(ok, 8'h00, 1'b1));
            end
            kbsq_pkg::OP_ENV: begin
                ok = apply_envelope(req);
                pending_results.push_back(status_result(ok, 8'h00, 1'b1));
            end
            kbsq_pkg::OP_READ: begin
                if (req.read_capacity == 7'd0) begin
                    pending_results.push_back(status_result(1'b0, 8'h00, 1'b1));
                end else begin
                    n = mirror_count;
                    if (n > req.read_capacity - 1) begin
                        n = req.read_capacity - 1;
                    end
                    if (n > kbsq_pkg::MAX_READ) begin
                        n = kbsq_pkg::MAX_READ;
                    end
                    if (n == kbsq_pkg::MAX_READ) begin
                        full_reads++;
                    end
                    // The count byte leads, then the bytes from the head of the queue.
                    pending_results.push_back(status_result(1'b1, n[7:0], n == 0));
                    for (int i = 0; i < n; i++) begin
                        pending_results.push_back(status_result(1'b1,
                            mirror_fifo[(mirror_head + i) % DEPTH], i + 1 == n));
                    end
                    mirror_head  = (mirror_head + n) % DEPTH;
                    mirror_count = mirror_count - n;
                end
            end
            default: begin
                pending_results.push_back(status_result(1'b0, 8'h00, 1'b1));
            end
        endcase
    endfunction

    // Every accepted result is compared with the oldest outstanding one.
    always @(posedge i_clk) begin
        kbsq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_fault($sformatf("unrequested result ok=%0d data=%02h last=%0d",
                    o_out_data.ok, o_out_data.data_byte, o_out_data.last));
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.ok !== want.ok || o_out_data.data_byte !== want.data_byte ||
                    o_out_data.last !== want.last || o_out_data.leds_now !== want.leds_now ||
                    o_out_data.repeat_now !== want.repeat_now ||
                    o_out_data.dropped_total !== want.dropped_total) begin
                    note_fault($sformatf({"expected ok=%0d data=%02h last=%0d leds=%0d ",
                        "rate=%0d drops=%0d, got ok=%0d data=%02h last=%0d leds=%0d ",
                        "rate=%0d drops=%0d"},
                        want.ok, want.data_byte, want.last, want.leds_now,
                        want.repeat_now, want.dropped_total,
                        o_out_data.ok, o_out_data.data_byte, o_out_data.last,
                        o_out_data.leds_now, o_out_data.repeat_now,
                        o_out_data.dropped_total));
                end
            end
        end
    end

    // Hard stop if the adapter hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d results outstanding.",
            cycle_count, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic kbsq_pkg::t_in_item key_req(logic [7:0] code, logic ext, logic down);
        kbsq_pkg::t_in_item req;
        req              = '0;
        req.opcode       = kbsq_pkg::OP_KEY;
        req.key_code     = code;
        req.key_extended = ext;
        req.key_down     = down;
        return req;
    endfunction

    function automatic kbsq_pkg::t_in_item env_req(logic [7:0] size, logic [7:0] tag,
                                                   logic [7:0] len, logic [7:0] cmd,
                                                   logic [7:0] arg, logic [7:0] arg2);
        kbsq_pkg::t_in_item req;
        req          = '0;
        req.opcode   = kbsq_pkg::OP_ENV;
        req.env_size = size;
        req.env_tag  = tag;
        req.env_len  = len;
        req.env_cmd  = cmd;
        req.env_arg  = arg;
        req.env_arg2 = arg2;
        return req;
    endfunction

    function automatic kbsq_pkg::t_in_item read_req(logic [6:0] cap);
        kbsq_pkg::t_in_item req;
        req               = '0;
        req.opcode        = kbsq_pkg::OP_READ;
        req.read_capacity = cap;
        return req;
    endfunction

    function automatic logic [7:0] random_scan_code();
        logic [7:0] code;
        code = 8'($urandom_range(255, 1));
        while (reserved_code(code)) begin
            code = 8'($urandom_range(255, 1));
        end
        return code;
    endfunction

    // Mostly well-formed requests with random content; unused fields carry noise.
    function automatic kbsq_pkg::t_in_item random_request();
        kbsq_pkg::t_in_item req;
        logic [95:0]        noise;
        int unsigned        kind;
        int unsigned        pick;
        noise = {$urandom, $urandom, $urandom};
        req   = noise[$bits(kbsq_pkg::t_in_item)-1:0];
        kind  = $urandom_range(99);
        if (kind < 45) begin
            req.opcode = kbsq_pkg::OP_KEY;
            if ($urandom_range(9) != 0) begin
                req.key_code = random_scan_code();
            end else begin
                case ($urandom_range(4))
                    0:       req.key_code = kbsq_pkg::CODE_NONE;
                    1:       req.key_code = kbsq_pkg::PFX_EXT;
                    2:       req.key_code = kbsq_pkg::CODE_E1;
                    3:       req.key_code = kbsq_pkg::PFX_BRK;
                    default: req.key_code = kbsq_pkg::CODE_F8;
                endcase
            end
        end else if (kind < 62) begin
            req.opcode  = kbsq_pkg::OP_ENV;
            req.env_tag = kbsq_pkg::TAG_K;
            pick        = $urandom_range(19);
            if (pick < 3) begin
                req.env_len = 8'd1;
                req.env_cmd = kbsq_pkg::CMD_RESET;
            end else if (pick < 11) begin
                req.env_len = 8'd2;
                req.env_cmd = kbsq_pkg::CMD_LEDS;
                if ($urandom_range(9) < 8) begin
                    req.env_arg = 8'($urandom_range(7));
                end
            end else begin
                req.env_len = 8'd3;
                req.env_cmd = kbsq_pkg::CMD_RATE;
                if ($urandom_range(9) < 8) begin
                    req.env_arg[7] = 1'b0;
                end
                if ($urandom_range(9) != 0) begin
                    req.env_arg2 = kbsq_pkg::RATE_TRAIL;
                end
            end
            req.env_size = 8'($urandom_range(255, req.env_len + 2));
            // A quarter of the envelopes are spoilt in their size, tag, length or command byte.
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0:       req.env_size = 8'($urandom_range(req.env_len + 1));
                    1:       req.env_tag  = 8'($urandom_range(255));
                    2:       req.env_len  = 8'($urandom_range(255));
                    default: req.env_cmd  = 8'($urandom_range(255));
                endcase
            end
        end else if (kind < 95) begin
            req.opcode = kbsq_pkg::OP_READ;
            pick       = $urandom_range(9);
            if (pick == 0) begin
                req.read_capacity = 7'd0;
            end else if (pick == 1) begin
                req.read_capacity = 7'($urandom_range(64, 63));
            end else begin
                req.read_capacity = 7'($urandom_range(12, 1));
            end
        end else begin
            req.opcode = OP_SPARE;
        end
        return req;
    endfunction

    // Presents one request, with an occasional gap before it, and waits for acceptance.
    task automatic send_request(input kbsq_pkg::t_in_item req);
        if (!calm && $urandom_range(99) < 30) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        requests_sent++;
        predict_results(req);
    endtask

    // Holds the request channel idle until every owed result has arrived.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Reserved codes and every prefix combination of an ordinary key.
    task automatic test_key_codes();
        send_request(key_req(kbsq_pkg::CODE_NONE, 1'b0, 1'b1));
        send_request(key_req(kbsq_pkg::PFX_EXT, 1'b1, 1'b1));
        send_request(key_req(kbsq_pkg::CODE_E1, 1'b0, 1'b0));
        send_request(key_req(kbsq_pkg::PFX_BRK, 1'b1, 1'b0));
        send_request(key_req(kbsq_pkg::CODE_F8, 1'b0, 1'b1));
        send_request(key_req(8'h1C, 1'b0, 1'b1));
        send_request(key_req(8'h75, 1'b1, 1'b1));
        send_request(key_req(8'h1C, 1'b0, 1'b0));
        send_request(key_req(8'hFF, 1'b1, 1'b0));
        send_request(key_req(8'h01, 1'b1, 1'b1));
    endtask

    // Zero capacity, count byte only, a short read and the unused opcode.
    task automatic test_read_requests();
        kbsq_pkg::t_in_item req;
        send_request(read_req(7'd0));
        send_request(read_req(7'd1));
        send_request(read_req(7'd3));
        req        = '1;
        req.opcode = OP_SPARE;
        send_request(req);
    endtask

    // Each command, each framing check and each argument limit.
    task automatic test_host_envelopes();
        send_request(env_req(8'd4, kbsq_pkg::TAG_K, 8'd2, kbsq_pkg::CMD_LEDS, 8'd7, 8'h00));
        send_request(env_req(8'd4, kbsq_pkg::TAG_K, 8'd2, kbsq_pkg::CMD_LEDS, 8'd8, 8'h00));
        send_request(env_req(8'd5, kbsq_pkg::TAG_K, 8'd3, kbsq_pkg::CMD_RATE, 8'h7F,
                             kbsq_pkg::RATE_TRAIL));
        send_request(env_req(8'd5, kbsq_pkg::TAG_K, 8'd3, kbsq_pkg::CMD_RATE, 8'h80,
                             kbsq_pkg::RATE_TRAIL));
        send_request(env_req(8'd5, kbsq_pkg::TAG_K, 8'd3, kbsq_pkg::CMD_RATE, 8'h10, 8'h00));
        send_request(env_req(8'd1, kbsq_pkg::TAG_K, 8'd0, kbsq_pkg::CMD_RESET, 8'h00, 8'h00));
        send_request(env_req(8'd0, kbsq_pkg::TAG_K, 8'd1, kbsq_pkg::CMD_RESET, 8'h00, 8'h00));
        send_request(env_req(8'd255, 8'h4A, 8'd1, kbsq_pkg::CMD_RESET, 8'h00, 8'h00));
        send_request(env_req(8'd3, kbsq_pkg::TAG_K, 8'd2, kbsq_pkg::CMD_LEDS, 8'd3, 8'h00));
        send_request(env_req(8'd4, kbsq_pkg::TAG_K, 8'd1, kbsq_pkg::CMD_LEDS, 8'd3, 8'h00));
        // The reset command clears the bytes still queued from the key tests.
        send_request(env_req(8'd3, kbsq_pkg::TAG_K, 8'd1, kbsq_pkg::CMD_RESET, 8'hFF, 8'hFF));
        send_request(read_req(7'd64));
    endtask

    // Fills the queue past the brim so that key events drop, then drains it with reads of capacity 64.
    task automatic test_overflow_and_drain();
        int unsigned near_full;
        for (int round = 0; round < 2; round++) begin
            near_full = 0;
            while (near_full < 6) begin
                if (mirror_count + 3 > DEPTH) begin
                    near_full++;
                end
                send_request(key_req(random_scan_code(), 1'($urandom_range(1)),
                                     1'($urandom_range(1))));
            end
            while (mirror_count != 0) begin
                send_request(read_req(7'd64));
            end
        end
    endtask

    // Random mix with a calm stretch and one pause until the adapter is empty.
    task automatic test_mixed_traffic(input int unsigned total);
        for (int k = 0; k < total; k++) begin
            calm = (k >= 120 && k < 200);
            if (k == 260) begin
                hold_until_drained();
            end
            send_request(random_request());
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_key_codes();
        test_read_requests();
        test_host_envelopes();
        test_overflow_and_drain();
        test_mixed_traffic(360);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results in %0d cycles.",
            requests_sent, results_seen, cycle_count);
        $display("Saw %0d dropped key events, %0d full-length reads, %0d faults.",
            drop_events, full_reads, fault_count);
        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== keyboard_scancode_queue_adapter.f =====
+incdir+rtl
rtl/kbsq_pkg.sv
rtl/kbsq_ctrl.sv
rtl/kbsq_datapath.sv
rtl/keyboard_scancode_queue_adapter.sv
verif/keyboard_scancode_queue_adapter_tb.sv
